// ===== rtl/assert_macros.svh =====
// Assertion macros for the quaternion ALU modules.
// Depends on nothing; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QALU_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("quaternion ALU assertion failed");
`define QALU_ASSERT_RESET(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("quaternion ALU reset assertion failed");
`else
`define QALU_ASSERT(label, clk, rst, prop)
`define QALU_ASSERT_RESET(label, clk, prop)
`endif
`endif

// ===== rtl/qalu_pkg.sv =====
// Package for the quaternion ALU: operation codes and fixed scale format.
// Depends on nothing; used by the datapath and the top level.
package qalu_pkg;

   typedef enum logic [2:0] {
      OP_MUL   = 3'd0,
      OP_ADD   = 3'd1,
      OP_SUB   = 3'd2,
      OP_SCALE = 3'd3,
      OP_CONJ  = 3'd4
   } op_type;

   localparam int OP_WIDTH   = 3;
   localparam int SCALE_WIDTH = 16;
   localparam int SCALE_FRAC  = 8;

endpackage

// ===== rtl/quaternion_alu_top.sv =====
// Top level of the quaternion ALU: input register, datapath and result register.
// Depends on qalu_pkg, qalu_datapath and assert_macros.svh.
//
// One beat is accepted every cycle while the result side does not stall. The request
// lands in an input register, a single combinational pass with sixteen parallel
// multipliers for the product, four for the scale and a four-term adder per component
// works it, and the saturated result is loaded into the result register and held there
// until taken. A stall on the result side holds both stages, and the input stage
// refills in the same cycle that the result register drains.
`include "assert_macros.svh"

module quaternion_alu_top #(
   parameter int COMPONENT_WIDTH = 16,
   parameter int FRACTION_BITS   = 14
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [qalu_pkg::OP_WIDTH-1:0]           req_operation,
   input  logic signed [COMPONENT_WIDTH-1:0]       req_a_w,
   input  logic signed [COMPONENT_WIDTH-1:0]       req_a_x,
   input  logic signed [COMPONENT_WIDTH-1:0]       req_a_y,
   input  logic signed [COMPONENT_WIDTH-1:0]       req_a_z,
   input  logic signed [COMPONENT_WIDTH-1:0]       req_b_w,
   input  logic signed [COMPONENT_WIDTH-1:0]       req_b_x,
   input  logic signed [COMPONENT_WIDTH-1:0]       req_b_y,
   input  logic signed [COMPONENT_WIDTH-1:0]       req_b_z,
   input  logic signed [qalu_pkg::SCALE_WIDTH-1:0] req_scale,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [COMPONENT_WIDTH-1:0]       rsp_r_w,
   output logic signed [COMPONENT_WIDTH-1:0]       rsp_r_x,
   output logic signed [COMPONENT_WIDTH-1:0]       rsp_r_y,
   output logic signed [COMPONENT_WIDTH-1:0]       rsp_r_z,
   output logic                                    rsp_saturated
);

   logic                                    in_valid_ff;
   logic [qalu_pkg::OP_WIDTH-1:0]           op_ff;
   logic signed [COMPONENT_WIDTH-1:0]       a_w_ff, a_x_ff, a_y_ff, a_z_ff;
   logic signed [COMPONENT_WIDTH-1:0]       b_w_ff, b_x_ff, b_y_ff, b_z_ff;
   logic signed [qalu_pkg::SCALE_WIDTH-1:0] scale_ff;

   logic                                    out_valid_ff;
   logic signed [COMPONENT_WIDTH-1:0]       r_w_ff, r_x_ff, r_y_ff, r_z_ff;
   logic                                    sat_ff;

   logic signed [COMPONENT_WIDTH-1:0]       r_w_in, r_x_in, r_y_in, r_z_in;
   logic                                    sat_in;
   logic                                    advance;
   logic                                    take;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         op_ff    <= req_operation;
         a_w_ff   <= req_a_w;
         a_x_ff   <= req_a_x;
         a_y_ff   <= req_a_y;
         a_z_ff   <= req_a_z;
         b_w_ff   <= req_b_w;
         b_x_ff   <= req_b_x;
         b_y_ff   <= req_b_y;
         b_z_ff   <= req_b_z;
         scale_ff <= req_scale;
      end
   end

   qalu_datapath #(
      .COMPONENT_WIDTH(COMPONENT_WIDTH),
      .FRACTION_BITS  (FRACTION_BITS)
   ) u_datapath (
      .operation(op_ff),
      .a_w      (a_w_ff),
      .a_x      (a_x_ff),
      .a_y      (a_y_ff),
      .a_z      (a_z_ff),
      .b_w      (b_w_ff),
      .b_x      (b_x_ff),
      .b_y      (b_y_ff),
      .b_z      (b_z_ff),
      .scale    (scale_ff),
      .r_w      (r_w_in),
      .r_x      (r_x_in),
      .r_y      (r_y_in),
      .r_z      (r_z_in),
      .saturated(sat_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r_w_ff <= r_w_in;
         r_x_ff <= r_x_in;
         r_y_ff <= r_y_in;
         r_z_ff <= r_z_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_r_w       = r_w_ff;
   assign rsp_r_x       = r_x_ff;
   assign rsp_r_y       = r_y_ff;
   assign rsp_r_z       = r_z_ff;
   assign rsp_saturated = sat_ff;

   `QALU_ASSERT_RESET(a_reset_empty, clock, reset |=> !in_valid_ff && !out_valid_ff)
   `QALU_ASSERT(a_advance_fills, clock, reset, advance |=> out_valid_ff)
   `QALU_ASSERT(a_unused_zero, clock, reset,
      (advance && op_ff > qalu_pkg::OP_CONJ) |=> ({r_w_ff, r_x_ff, r_y_ff, r_z_ff, sat_ff} == '0))
   `QALU_ASSERT(a_conj_scalar, clock, reset,
      (advance && op_ff == qalu_pkg::OP_CONJ) |=> r_w_ff == $past(a_w_ff))

endmodule

// ===== rtl/qalu_sat.sv =====
// Signed saturation of one wide result component to the component width.
// Depends on nothing; instantiated once per component by qalu_datapath.
module qalu_sat #(
   parameter int IN_WIDTH  = 34,
   parameter int OUT_WIDTH = 16
) (
   input  logic signed [IN_WIDTH-1:0]  value_in,
   output logic signed [OUT_WIDTH-1:0] value_out,
   output logic                        clamped
);

   logic [IN_WIDTH-OUT_WIDTH:0] top_bits;

   assign top_bits = value_in[IN_WIDTH-1:OUT_WIDTH-1];

   always_comb begin
      clamped = !((&top_bits) || !(|top_bits));
      if (!clamped) begin
         value_out = value_in[OUT_WIDTH-1:0];
      end else if (value_in[IN_WIDTH-1]) begin
         value_out = {1'b1, {(OUT_WIDTH-1){1'b0}}};
      end else begin
         value_out = {1'b0, {(OUT_WIDTH-1){1'b1}}};
      end
   end

endmodule

// ===== rtl/qalu_datapath.sv =====
// Single-pass quaternion arithmetic: product, sum, difference, scale, conjugate; unused codes give zero.
// Depends on qalu_pkg and qalu_sat.
module qalu_datapath #(
   parameter int COMPONENT_WIDTH = 16,
   parameter int FRACTION_BITS   = 14
) (
   input  logic [qalu_pkg::OP_WIDTH-1:0]           operation,
   input  logic signed [COMPONENT_WIDTH-1:0]       a_w,
   input  logic signed [COMPONENT_WIDTH-1:0]       a_x,
   input  logic signed [COMPONENT_WIDTH-1:0]       a_y,
   input  logic signed [COMPONENT_WIDTH-1:0]       a_z,
   input  logic signed [COMPONENT_WIDTH-1:0]       b_w,
   input  logic signed [COMPONENT_WIDTH-1:0]       b_x,
   input  logic signed [COMPONENT_WIDTH-1:0]       b_y,
   input  logic signed [COMPONENT_WIDTH-1:0]       b_z,
   input  logic signed [qalu_pkg::SCALE_WIDTH-1:0] scale,
   output logic signed [COMPONENT_WIDTH-1:0]       r_w,
   output logic signed [COMPONENT_WIDTH-1:0]       r_x,
   output logic signed [COMPONENT_WIDTH-1:0]       r_y,
   output logic signed [COMPONENT_WIDTH-1:0]       r_z,
   output logic                                    saturated
);

   localparam int W      = COMPONENT_WIDTH;
   localparam int SW     = qalu_pkg::SCALE_WIDTH;
   localparam int PROD_W = 2 * W + 2;
   localparam int WIDE   = (PROD_W > W + SW) ? PROD_W : W + SW;

   logic signed [W-1:0]      a [4];
   logic signed [W-1:0]      b [4];
   logic signed [2*W-1:0]    p [4][4];
   logic signed [W+SW-1:0]   ps [4];
   logic signed [WIDE-1:0]   hsum [4];
   logic signed [WIDE-1:0]   sel [4];
   logic signed [W-1:0]      res [4];
   logic [3:0]               clamped;

   assign a[0] = a_w;
   assign a[1] = a_x;
   assign a[2] = a_y;
   assign a[3] = a_z;
   assign b[0] = b_w;
   assign b[1] = b_x;
   assign b[2] = b_y;
   assign b[3] = b_z;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         ps[i] = a[i] * scale;
         for (int j = 0; j < 4; j++) begin
            p[i][j] = a[i] * b[j];
         end
      end
   end

   always_comb begin
      hsum[0] = WIDE'(p[0][0]) - WIDE'(p[1][1]) - WIDE'(p[2][2]) - WIDE'(p[3][3]);
      hsum[1] = WIDE'(p[0][1]) + WIDE'(p[1][0]) + WIDE'(p[2][3]) - WIDE'(p[3][2]);
      hsum[2] = WIDE'(p[0][2]) - WIDE'(p[1][3]) + WIDE'(p[2][0]) + WIDE'(p[3][1]);
      hsum[3] = WIDE'(p[0][3]) + WIDE'(p[1][2]) - WIDE'(p[2][1]) + WIDE'(p[3][0]);
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         unique case (qalu_pkg::op_type'(operation))
            qalu_pkg::OP_MUL: begin
               sel[i] = hsum[i] >>> FRACTION_BITS;
            end
            qalu_pkg::OP_ADD: begin
               sel[i] = WIDE'(a[i]) + WIDE'(b[i]);
            end
            qalu_pkg::OP_SUB: begin
               sel[i] = WIDE'(a[i]) - WIDE'(b[i]);
            end
            qalu_pkg::OP_SCALE: begin
               sel[i] = WIDE'(ps[i]) >>> qalu_pkg::SCALE_FRAC;
            end
            qalu_pkg::OP_CONJ: begin
               sel[i] = (i == 0) ? WIDE'(a[i]) : -WIDE'(a[i]);
            end
            default: begin
               sel[i] = '0;
            end
         endcase
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_sat
      qalu_sat #(
         .IN_WIDTH (WIDE),
         .OUT_WIDTH(W)
      ) u_sat (
         .value_in (sel[g]),
         .value_out(res[g]),
         .clamped  (clamped[g])
      );
   end

   assign r_w       = res[0];
   assign r_x       = res[1];
   assign r_y       = res[2];
   assign r_z       = res[3];
   assign saturated = |clamped;

endmodule

// ===== test/quaternion_alu_top_tb.sv =====
// Self-checking testbench for quaternion_alu_top: drives operation beats through the
// valid/ready request channel and compares every result beat with a built-in predictor.
// Depends on qalu_pkg and the quaternion_alu_top RTL only.
module quaternion_alu_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COMPONENT_WIDTH = 16;
   localparam int FRACTION_BITS   = 14;
   localparam int OP_W            = qalu_pkg::OP_WIDTH;
   localparam int SC_W            = qalu_pkg::SCALE_WIDTH;
   localparam int SC_FRAC         = qalu_pkg::SCALE_FRAC;
   localparam longint COMP_MAX    = (longint'(1) <<< (COMPONENT_WIDTH - 1)) - 1;
   localparam longint COMP_MIN    = -COMP_MAX - 1;
   localparam int Q_ONE           = 1 << FRACTION_BITS;
   localparam int SCALE_ONE       = 1 << SC_FRAC;
   localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;
   localparam int RESET_CYCLES    = 8;
   localparam int DRAIN_CYCLES    = 8;
   localparam int TIMEOUT_NS      = 2_000_000;

   typedef logic signed [COMPONENT_WIDTH-1:0] comp_type;
   typedef logic [OP_W-1:0] opcode_type;

   typedef struct {
      opcode_type             operation;
      comp_type               a [4];
      comp_type               b [4];
      logic signed [SC_W-1:0] scale;
   } quat_req_type;

   typedef struct {
      comp_type r [4];
      logic     saturated;
   } quat_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   opcode_type req_operation = '0;
   comp_type req_a_w = '0, req_a_x = '0, req_a_y = '0, req_a_z = '0;
   comp_type req_b_w = '0, req_b_x = '0, req_b_y = '0, req_b_z = '0;
   logic signed [SC_W-1:0] req_scale = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   comp_type rsp_r_w, rsp_r_x, rsp_r_y, rsp_r_z;
   logic rsp_saturated;

   bit idle_enabled = 1'b0;
   int unsigned stall_left = 0;
   int unsigned error_count = 0;
   quat_rsp_type expected_results [$];
   string comp_name [4] = '{"r_w", "r_x", "r_y", "r_z"};

   quaternion_alu_top #(
      .COMPONENT_WIDTH(COMPONENT_WIDTH),
      .FRACTION_BITS(FRACTION_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_a_w(req_a_w),
      .req_a_x(req_a_x),
      .req_a_y(req_a_y),
      .req_a_z(req_a_z),
      .req_b_w(req_b_w),
      .req_b_x(req_b_x),
      .req_b_y(req_b_y),
      .req_b_z(req_b_z),
      .req_scale(req_scale),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_r_w(rsp_r_w),
      .rsp_r_x(rsp_r_x),
      .rsp_r_y(rsp_r_y),
      .rsp_r_z(rsp_r_z),
      .rsp_saturated(rsp_saturated)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic quat_rsp_type predict_quaternion(input quat_req_type it);
      quat_rsp_type res;
      longint a [4];
      longint b [4];
      longint raw [4];
      longint sc;
      sc = it.scale;
      res.saturated = 1'b0;
      for (int i = 0; i < 4; i++) begin
         a[i] = it.a[i];
         b[i] = it.b[i];
         raw[i] = 0;
      end
      case (it.operation)
         qalu_pkg::OP_MUL: begin
            raw[0] = (a[0] * b[0] - a[1] * b[1] - a[2] * b[2] - a[3] * b[3]) >>> FRACTION_BITS;
            raw[1] = (a[0] * b[1] + a[1] * b[0] + a[2] * b[3] - a[3] * b[2]) >>> FRACTION_BITS;
            raw[2] = (a[0] * b[2] - a[1] * b[3] + a[2] * b[0] + a[3] * b[1]) >>> FRACTION_BITS;
            raw[3] = (a[0] * b[3] + a[1] * b[2] - a[2] * b[1] + a[3] * b[0]) >>> FRACTION_BITS;
         end
         qalu_pkg::OP_ADD:   for (int i = 0; i < 4; i++) raw[i] = a[i] + b[i];
         qalu_pkg::OP_SUB:   for (int i = 0; i < 4; i++) raw[i] = a[i] - b[i];
         qalu_pkg::OP_SCALE: for (int i = 0; i < 4; i++) raw[i] = (a[i] * sc) >>> SC_FRAC;
         qalu_pkg::OP_CONJ: begin
            raw[0] = a[0];
            for (int i = 1; i < 4; i++) raw[i] = -a[i];
         end
         default: ;
      endcase
      for (int i = 0; i < 4; i++) begin
         if (raw[i] > COMP_MAX) begin
            raw[i] = COMP_MAX;
            res.saturated = 1'b1;
         end
         if (raw[i] < COMP_MIN) begin
            raw[i] = COMP_MIN;
            res.saturated = 1'b1;
         end
         res.r[i] = raw[i][COMPONENT_WIDTH-1:0];
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("mismatch at %0t ns: %s", $time, what);
   endtask

   // Captures each accepted request beat, then checks any result beat taken at the same edge.
   always @(posedge clock) begin : result_check
      quat_req_type seen;
      quat_rsp_type got;
      quat_rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            seen.operation = req_operation;
            seen.a = '{req_a_w, req_a_x, req_a_y, req_a_z};
            seen.b = '{req_b_w, req_b_x, req_b_y, req_b_z};
            seen.scale = req_scale;
            expected_results.push_back(predict_quaternion(seen));
         end
         if (rsp_valid && rsp_ready) begin
            got.r = '{rsp_r_w, rsp_r_x, rsp_r_y, rsp_r_z};
            got.saturated = rsp_saturated;
            if (expected_results.size() == 0) begin
               report_mismatch("result beat with no request outstanding");
            end else begin
               want = expected_results.pop_front();
               for (int i = 0; i < 4; i++) begin
                  if (got.r[i] !== want.r[i])
                     report_mismatch($sformatf("%s got %0d expected %0d",
                                               comp_name[i], got.r[i], want.r[i]));
               end
               if (got.saturated !== want.saturated)
                  report_mismatch($sformatf("saturated got %b expected %b",
                                            got.saturated, want.saturated));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!idle_enabled) begin
         stall_left <= 0;
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 17);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic quat_req_type make_item(input opcode_type op,
                                              input int aw, input int ax, input int ay,
                                              input int az, input int bw, input int bx,
                                              input int by, input int bz, input int sc);
      quat_req_type it;
      it.operation = op;
      it.a = '{aw[COMPONENT_WIDTH-1:0], ax[COMPONENT_WIDTH-1:0],
               ay[COMPONENT_WIDTH-1:0], az[COMPONENT_WIDTH-1:0]};
      it.b = '{bw[COMPONENT_WIDTH-1:0], bx[COMPONENT_WIDTH-1:0],
               by[COMPONENT_WIDTH-1:0], bz[COMPONENT_WIDTH-1:0]};
      it.scale = sc[SC_W-1:0];
      return it;
   endfunction

   function automatic int rand_component();
      case ($urandom_range(0, 7))
         0: return int'(COMP_MAX);
         1: return int'(COMP_MIN);
         2, 3, 4: return int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE;
         default: return int'($urandom);
      endcase
   endfunction

   function automatic quat_req_type random_item();
      opcode_type op;
      int sc;
      if ($urandom_range(0, 15) == 0)
         op = opcode_type'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      else
         op = opcode_type'($urandom_range(qalu_pkg::OP_MUL, qalu_pkg::OP_CONJ));
      if ($urandom_range(0, 2) == 0)
         sc = int'($urandom_range(0, 8 * SCALE_ONE)) - 4 * SCALE_ONE;
      else
         sc = rand_component();
      return make_item(op, rand_component(), rand_component(), rand_component(),
                       rand_component(), rand_component(), rand_component(),
                       rand_component(), rand_component(), sc);
   endfunction

   task automatic send_item(input quat_req_type it);
      if (idle_enabled && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= it.operation;
      req_a_w <= it.a[0];
      req_a_x <= it.a[1];
      req_a_y <= it.a[2];
      req_a_z <= it.a[3];
      req_b_w <= it.b[0];
      req_b_x <= it.b[1];
      req_b_y <= it.b[2];
      req_b_z <= it.b[3];
      req_scale <= it.scale;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic test_multiply_corners();
      int mx;
      int mn;
      mx = int'(COMP_MAX);
      mn = int'(COMP_MIN);
      send_item(make_item(qalu_pkg::OP_MUL, Q_ONE, 0, 0, 0, 1234, -2345, 3456, -4567, 0));
      send_item(make_item(qalu_pkg::OP_MUL, 8192, 8192, 8192, 8192,
                          8192, -8192, 8192, -8192, 0));
      send_item(make_item(qalu_pkg::OP_MUL, mx, mx, mx, mx, mx, mx, mx, mx, 0));
      send_item(make_item(qalu_pkg::OP_MUL, mn, mn, mn, mn, mn, mn, mn, mn, 0));
      send_item(make_item(qalu_pkg::OP_MUL, mx, mx, mx, mx, mn, mn, mn, mn, 0));
      send_item(make_item(qalu_pkg::OP_MUL, -1, 0, 0, 0, 1, 0, 0, 0, 0));
      send_item(make_item(qalu_pkg::OP_MUL, 0, 0, 0, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_add_subtract_corners();
      int mx;
      int mn;
      mx = int'(COMP_MAX);
      mn = int'(COMP_MIN);
      send_item(make_item(qalu_pkg::OP_ADD, mx, mx, mx, mx, mx, mx, mx, mx, 0));
      send_item(make_item(qalu_pkg::OP_ADD, mn, mn, mn, mn, mn, mn, mn, mn, 0));
      send_item(make_item(qalu_pkg::OP_ADD, mx, mn, mx, mn, mn, mx, mn, mx, 0));
      send_item(make_item(qalu_pkg::OP_SUB, mn, mn, mn, mn, mx, mx, mx, mx, 0));
      send_item(make_item(qalu_pkg::OP_SUB, mx, mx, mx, mx, mn, mn, mn, mn, 0));
      send_item(make_item(qalu_pkg::OP_SUB, 0, 0, 0, 0, mn, 1, -1, mx, 0));
   endtask

   task automatic test_scale_corners();
      int mx;
      int mn;
      mx = int'(COMP_MAX);
      mn = int'(COMP_MIN);
      send_item(make_item(qalu_pkg::OP_SCALE, mx, mx, mx, mx, 0, 0, 0, 0, mx));
      send_item(make_item(qalu_pkg::OP_SCALE, mn, mn, mn, mn, 0, 0, 0, 0, mn));
      send_item(make_item(qalu_pkg::OP_SCALE, 1234, -4321, mx, mn, mx, mn, 0, 0, SCALE_ONE));
      send_item(make_item(qalu_pkg::OP_SCALE, 1, -1, mx, mn, 0, 0, 0, 0, -1));
      send_item(make_item(qalu_pkg::OP_SCALE, mx, mn, 77, -77, 0, 0, 0, 0, 0));
   endtask

   task automatic test_conjugate_and_unused();
      int mx;
      int mn;
      mx = int'(COMP_MAX);
      mn = int'(COMP_MIN);
      send_item(make_item(qalu_pkg::OP_CONJ, mn, mn, mn, mn, mx, mx, mx, mx, mx));
      send_item(make_item(qalu_pkg::OP_CONJ, mx, mx, 0, -1, 0, 0, 0, 0, 0));
      send_item(make_item(qalu_pkg::OP_CONJ, -1, 1, mx, -Q_ONE, mn, mn, mn, mn, mn));
      for (int code = OP_UNUSED_LO; code <= OP_UNUSED_HI; code++)
         send_item(make_item(opcode_type'(code), -1, -1, -1, -1, -1, -1, -1, -1, -1));
   endtask

   // Idling is set anew every hundred beats and is off for every fourth hundred, so that stretches of both kinds occur.
   task automatic test_random_with_idling();
      for (int n = 0; n < 1000; n++) begin
         if (n % 100 == 0)
            idle_enabled <= ((n / 100) % 4 != 3);
         send_item(random_item());
      end
   endtask

   task automatic test_random_streaming();
      idle_enabled <= 1'b0;
      for (int n = 0; n < 600; n++)
         send_item(random_item());
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_multiply_corners();
      test_add_subtract_corners();
      test_scale_corners();
      test_conjugate_and_unused();
      test_random_with_idling();
      test_random_streaming();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
